// ===== src/apoc_pkg.sv =====
// ----------------------------------------------------------------------------
// apoc_pkg
// shared types and constants for the box push-out block
// ----------------------------------------------------------------------------
package apoc_pkg;

  localparam int MaxSolids  = 64;
  localparam int MaxPickups = 64;
  localparam int IdxBits    = 6;
  localparam int CntBits    = 7;
  localparam int CoordBits  = 16;
  localparam int SizeBits   = 12;

  typedef enum logic [1:0] {
    OP_LOAD_SOLID  = 2'd0,
    OP_LOAD_PICKUP = 2'd1,
    OP_RESOLVE     = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SOLID,
    ST_PICKUP,
    ST_COUNT,
    ST_DONE
  } state_e;

  localparam logic CFG_SOLID_COUNT  = 1'b0;
  localparam logic CFG_PICKUP_COUNT = 1'b1;

  typedef struct packed {
    logic signed [CoordBits-1:0] left;
    logic signed [CoordBits-1:0] top;
    logic [SizeBits-1:0]         width;
    logic [SizeBits-1:0]         height;
  } rect_t;

endpackage

// ===== src/aabb_push_out_collision.sv =====
// ----------------------------------------------------------------------------
// aabb_push_out_collision
// box push-out against a solid table, pickup collection against a pickup table
// ----------------------------------------------------------------------------
// one input beat per item, one result beat per item, valid/stall on both
// sides. op load solid / load pickup writes one table entry (pickup load also
// clears its taken bit); op resolve walks the solid table in index order,
// pushing the box out of each overlapping solid along the smaller overlap
// axis, then walks the pickup table marking overlapped untaken pickups, then
// recounts the taken bits among the pickups in use.
// timing, counts clamped to 64: a resolve result beat follows its input beat
// after the solid walk, the pickup walk and the recount, a load or reserved
// op result beat after the recount only; the single read port of each table
// memory (one entry a cycle) sets this. the next input beat is accepted
// only once the previous item has moved to the output register.
// one item in flight plus one result beat waiting in the output register; a
// stalled result holds, and the input stalls while any item is in flight,
// even a finished one waiting. reset clears counts, taken bits and control;
// table contents are undefined until loaded. the user must write counts
// through cfg only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module aabb_push_out_collision (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [6:0]                         cfg_data_i,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op_i,
  input  logic [5:0]                         entry_index_i,
  input  logic signed [15:0]                 box_left_i,
  input  logic signed [15:0]                 box_top_i,
  input  logic [11:0]                        box_width_i,
  input  logic [11:0]                        box_height_i,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 new_left_o,
  output logic signed [15:0]                 new_top_o,
  output logic                               stop_horizontal_o,
  output logic                               stop_vertical_o,
  output logic                               landed_o,
  output logic [6:0]                         pickups_now_o,
  output logic [6:0]                         pickups_taken_o,
  output logic                               all_taken_o
);
  import apoc_pkg::*;

  // tables and taken bits
  rect_t solid_mem [MaxSolids];
  rect_t pick_mem  [MaxPickups];
  logic [MaxPickups-1:0] taken_q;

  logic [CntBits-1:0] solid_cnt_q, pick_cnt_q, ns, np;
  state_e state_q, state_d;
  op_e    op_q;
  rect_t  box_q;
  logic [CntBits-1:0] idx_q, idx_d;
  logic   rd_valid_q;               // read data of previous index is live
  logic [IdxBits-1:0] rd_idx_q;
  rect_t  solid_rd_q, pick_rd_q;
  logic   sh_q, sv_q, land_q;
  logic [CntBits-1:0] now_q, tcnt_q;

  // output register, holds one finished result beat
  logic                        res_valid_q;
  logic signed [CoordBits-1:0] res_left_q, res_top_q;
  logic                        res_sh_q, res_sv_q, res_land_q, res_all_q;
  logic [CntBits-1:0]          res_now_q, res_taken_q;
  logic                        res_load;

  assign ns = (solid_cnt_q > CntBits'(MaxSolids)) ? CntBits'(MaxSolids) : solid_cnt_q;
  assign np = (pick_cnt_q > CntBits'(MaxPickups)) ? CntBits'(MaxPickups) : pick_cnt_q;

  logic accept;
  assign in_stall = (state_q != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // finished item moves to the output register once it is free or being taken
  assign res_load = (state_q == ST_DONE) && (!res_valid_q || !out_stall);

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solid_cnt_q <= '0;
      pick_cnt_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SOLID_COUNT) solid_cnt_q <= cfg_data_i;
      else                                pick_cnt_q  <= cfg_data_i;
    end
  end

  // memory reads: one entry a cycle at idx_q
  always_ff @(posedge clk_i) begin
    solid_rd_q <= solid_mem[idx_q[IdxBits-1:0]];
    pick_rd_q  <= pick_mem[idx_q[IdxBits-1:0]];
    if (accept && op_e'(op_i) == OP_LOAD_SOLID)
      solid_mem[entry_index_i] <= '{box_left_i, box_top_i, box_width_i, box_height_i};
    if (accept && op_e'(op_i) == OP_LOAD_PICKUP)
      pick_mem[entry_index_i] <= '{box_left_i, box_top_i, box_width_i, box_height_i};
  end

  // overlap against the entry just read
  logic hit_s, hit_p;
  logic [SizeBits:0] ow_s, oh_s, ow_p, oh_p;
  apoc_overlap u_ov_s (.a_i(box_q), .b_i(solid_rd_q), .hit_o(hit_s), .ow_o(ow_s), .oh_o(oh_s));
  apoc_overlap u_ov_p (.a_i(box_q), .b_i(pick_rd_q),  .hit_o(hit_p), .ow_o(ow_p), .oh_o(oh_p));

  // saturating push, result fits coordinate range
  function automatic logic signed [CoordBits-1:0] sat(input logic signed [CoordBits+1:0] v);
    logic signed [CoordBits+1:0] mx, mn;
    mx = (CoordBits+2)'((1 <<< (CoordBits-1)) - 1);
    mn = -mx - 1;
    if (v > mx) sat = mx[CoordBits-1:0];
    else if (v < mn) sat = mn[CoordBits-1:0];
    else sat = v[CoordBits-1:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          if (op_e'(op_i) == OP_RESOLVE) state_d = ST_SOLID;
          else                           state_d = ST_COUNT;
        end
      end
      ST_SOLID: begin
        // reads run one ahead; finish after last entry evaluated
        if (rd_valid_q && CntBits'(rd_idx_q) + 1'b1 >= ns || ns == '0) begin
          state_d = ST_PICKUP;
          idx_d   = '0;
        end else if (!rd_valid_q || !hit_s) begin
          idx_d = (idx_q < ns) ? idx_q + 1'b1 : idx_q;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_PICKUP: begin
        if (rd_valid_q && CntBits'(rd_idx_q) + 1'b1 >= np || np == '0) begin
          state_d = ST_COUNT;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_COUNT: begin
        if (idx_q >= np) state_d = ST_DONE;
        else             idx_d   = idx_q + 1'b1;
      end
      ST_DONE: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // a box move changes later overlap only through box_q, which updates at the
  // same edge the next entry is read, so there is no hazard on the box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      rd_idx_q    <= '0;
      taken_q     <= '0;
      op_q        <= OP_NONE;
      box_q       <= '0;
      sh_q        <= 1'b0;
      sv_q        <= 1'b0;
      land_q      <= 1'b0;
      now_q       <= '0;
      tcnt_q      <= '0;
      res_valid_q <= 1'b0;
      res_left_q  <= '0;
      res_top_q   <= '0;
      res_sh_q    <= 1'b0;
      res_sv_q    <= 1'b0;
      res_land_q  <= 1'b0;
      res_now_q   <= '0;
      res_taken_q <= '0;
      res_all_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_idx_q <= idx_q[IdxBits-1:0];
      rd_valid_q <= ((state_q == ST_SOLID && idx_q < ns) ||
                     (state_q == ST_PICKUP && idx_q < np)) && (state_d == state_q);
      if (res_load)        res_valid_q <= 1'b1;
      else if (!out_stall) res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (accept) begin
          op_q   <= op_e'(op_i);
          box_q  <= '{box_left_i, box_top_i, box_width_i, box_height_i};
          sh_q   <= 1'b0;
          sv_q   <= 1'b0;
          land_q <= 1'b0;
          now_q  <= '0;
          tcnt_q <= '0;
          if (op_e'(op_i) == OP_LOAD_PICKUP) taken_q[entry_index_i] <= 1'b0;
        end
        ST_SOLID: if (rd_valid_q && hit_s) begin
          if (ow_s < oh_s) begin
            sh_q <= 1'b1;
            box_q.left <= (box_q.left < solid_rd_q.left)
              ? sat((CoordBits+2)'(box_q.left) - (CoordBits+2)'(ow_s))
              : sat((CoordBits+2)'(box_q.left) + (CoordBits+2)'(ow_s));
          end else begin
            sv_q <= 1'b1;
            if (box_q.top < solid_rd_q.top) begin
              land_q <= 1'b1;
              box_q.top <= sat((CoordBits+2)'(box_q.top) - (CoordBits+2)'(oh_s));
            end else begin
              box_q.top <= sat((CoordBits+2)'(box_q.top) + (CoordBits+2)'(oh_s));
            end
          end
        end
        ST_PICKUP: if (rd_valid_q && hit_p && !taken_q[rd_idx_q]) begin
          taken_q[rd_idx_q] <= 1'b1;
          now_q <= now_q + 1'b1;
        end
        ST_COUNT: begin
          if (idx_q < np && taken_q[idx_q[IdxBits-1:0]]) tcnt_q <= tcnt_q + 1'b1;
        end
        ST_DONE: if (res_load) begin
          res_left_q  <= (op_q == OP_RESOLVE) ? box_q.left : '0;
          res_top_q   <= (op_q == OP_RESOLVE) ? box_q.top  : '0;
          res_sh_q    <= sh_q;
          res_sv_q    <= sv_q;
          res_land_q  <= land_q;
          res_now_q   <= now_q;
          res_taken_q <= tcnt_q;
          res_all_q   <= (tcnt_q == np);
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    out_valid         = res_valid_q;
    new_left_o        = res_left_q;
    new_top_o         = res_top_q;
    stop_horizontal_o = res_sh_q;
    stop_vertical_o   = res_sv_q;
    landed_o          = res_land_q;
    pickups_now_o     = res_now_q;
    pickups_taken_o   = res_taken_q;
    all_taken_o       = res_all_q;
  end

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid &&
      $stable({new_left_o, new_top_o, stop_horizontal_o, stop_vertical_o, landed_o,
               pickups_now_o, pickups_taken_o, all_taken_o}))
    else $error("stalled result changed");
  // no new beat while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
  // load never reports a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && op_q != OP_RESOLVE) |-> !(sh_q || sv_q || land_q) && now_q == '0)
    else $error("load with push flags");
  // landing implies a vertical push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    land_q |-> sv_q) else $error("landed without vertical stop");

endmodule

// ===== src/apoc_overlap.sv =====
// ----------------------------------------------------------------------------
// apoc_overlap
// strict overlap test between two boxes, with overlap extents
// ----------------------------------------------------------------------------
module apoc_overlap (
  input  apoc_pkg::rect_t a_i,
  input  apoc_pkg::rect_t b_i,
  output logic            hit_o,
  output logic [apoc_pkg::SizeBits:0] ow_o,
  output logic [apoc_pkg::SizeBits:0] oh_o
);
  import apoc_pkg::*;

  logic signed [CoordBits+1:0] ar, br, ab, bb, lo_x, lo_y, hi_x, hi_y, w, h;

  always_comb begin
    ar = (CoordBits+2)'(a_i.left) + (CoordBits+2)'({1'b0, a_i.width});
    br = (CoordBits+2)'(b_i.left) + (CoordBits+2)'({1'b0, b_i.width});
    ab = (CoordBits+2)'(a_i.top) + (CoordBits+2)'({1'b0, a_i.height});
    bb = (CoordBits+2)'(b_i.top) + (CoordBits+2)'({1'b0, b_i.height});
    hi_x = (ar < br) ? ar : br;
    hi_y = (ab < bb) ? ab : bb;
    lo_x = (a_i.left > b_i.left) ? (CoordBits+2)'(a_i.left) : (CoordBits+2)'(b_i.left);
    lo_y = (a_i.top > b_i.top) ? (CoordBits+2)'(a_i.top) : (CoordBits+2)'(b_i.top);
    w = hi_x - lo_x;
    h = hi_y - lo_y;
    hit_o = (w > 0) && (h > 0);
    ow_o = w[SizeBits:0];
    oh_o = h[SizeBits:0];
  end

endmodule
